// ===== hw/rtl/cscan_disk_scheduler_macros.svh =====
// assertion macros for the c-scan disk scheduler
// expects clk and rst_n in the scope where a macro is used
`ifndef CSCAN_DISK_SCHEDULER_MACROS_SVH
`define CSCAN_DISK_SCHEDULER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define CSCAN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define CSCAN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cscan_pkg.sv =====
// shared types and constants for the c-scan disk scheduler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cscan_pkg;

    // sizing
    localparam int MAX_REQUESTS = 32;
    localparam int TRACK_BITS   = 16;
    localparam int DEPTH        = MAX_REQUESTS + 3;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int POS_W        = $clog2(DEPTH);
    localparam int FIELD_W      = 16;
    localparam int SEEK_W       = 18;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // largest track value that fits in TRACK_BITS
    localparam logic [FIELD_W-1:0] TRACK_MASK = FIELD_W'((32'd1 << TRACK_BITS) - 32'd1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_TRACK  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = CFG_IDX_W'(2);

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] TRACK_COUNT_RST = CFG_DATA_W'(200);
    localparam logic [CFG_DATA_W-1:0] HEAD_TRACK_RST  = '0;

    typedef logic [TRACK_BITS-1:0] track_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [SEEK_W-1:0]     seek_t;

    // operation applied to every cell of the chain in the same cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROT_DN,
        OP_ROT_UP
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        track_t    ins_val;
        cnt_t      count;
    } chain_cmd_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] track_count;
        logic [CFG_DATA_W-1:0] head_track;
        logic                  direction;
    } cfg_t;

    typedef struct packed {
        logic               strobe;
        logic [FIELD_W-1:0] track;
        logic               after_jump;
        seek_t              seek;
        logic               overflow;
        logic               end_of_run;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cscan_cell.sv =====
// one cell of the sorted track chain: holds one track and trades with its neighbors
// depends on cscan_pkg
`timescale 1ns / 1ps
`default_nettype none

module cscan_cell
(
    input  logic                  clk,
    input  cscan_pkg::chain_cmd_t cmd,
    input  cscan_pkg::cnt_t       idx,
    input  cscan_pkg::track_t     lo_val,
    input  logic                  lo_gt,
    input  cscan_pkg::track_t     hi_val,
    output cscan_pkg::track_t     val,
    output logic                  gt
);
    import cscan_pkg::*;

    track_t val_reg;
    track_t val_next;

    // empty cells count as greater so the new track lands at the end
    assign gt  = (idx >= cmd.count) || (val_reg > cmd.ins_val);
    assign val = val_reg;

    // insert shifts the greater part up by one; rotations move the whole ring
    always_comb
    begin
        unique case (cmd.op)
            OP_HOLD:   val_next = val_reg;
            OP_INSERT: val_next = gt ? (lo_gt ? lo_val : cmd.ins_val) : val_reg;
            OP_ROT_DN: val_next = hi_val;
            OP_ROT_UP: val_next = lo_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cscan_ctrl.sv =====
// sequencer: batch loading, wrap insertion, ring alignment and result generation
// depends on cscan_pkg; drives the cell chain of the top level
`timescale 1ns / 1ps
`default_nettype none

module cscan_ctrl
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [cscan_pkg::FIELD_W-1:0]       request_track,
    input  logic                                last_request,
    input  cscan_pkg::cfg_t                     cfg,
    input  cscan_pkg::track_t                   cell0,
    output logic                                busy,
    output cscan_pkg::chain_cmd_t               cmd,
    output cscan_pkg::result_t                  res
);
    import cscan_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_ALIGN = 3'd2;
    localparam logic [2:0] ST_SEEK  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    cnt_t       count_reg, count_next;
    logic       dropped_reg, dropped_next;
    logic [1:0] step_reg, step_next;
    pos_t       pos_reg, pos_next;
    cnt_t       emit_reg, emit_next;
    logic       dir_reg, dir_next;
    logic       jump_reg, jump_next;
    logic       strobe_reg, strobe_next;
    track_t     last_reg, last_next;
    track_t     head_reg, head_next;
    track_t     prev_reg, prev_next;
    seek_t      seek_reg, seek_next;
    result_t    res_reg, res_next;

    logic               accept;
    logic               room;
    logic [FIELD_W-1:0] last_w;
    logic [FIELD_W-1:0] last_m;
    logic [FIELD_W-1:0] head_m;
    track_t             c0;
    logic               valid0;
    logic               skip;
    track_t             diff;
    logic               first;
    logic               jump_now;
    logic               done_now;
    pos_t               pos_dn;
    pos_t               pos_up;
    seek_t              seek_sum;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign room   = count_reg < CNT_W'(MAX_REQUESTS);

    // last track and clamped head from the registers at batch close
    assign last_w = (cfg.track_count == '0) ? '0 : cfg.track_count - FIELD_W'(1);
    assign last_m = (last_w > TRACK_MASK) ? TRACK_MASK : last_w;
    assign head_m = (cfg.head_track > last_m) ? last_m : cfg.head_track;

    // front cell of the ring, clamped to the last track
    assign c0     = (cell0 > last_reg) ? last_reg : cell0;
    assign valid0 = CNT_W'(pos_reg) < count_reg;
    assign skip   = !valid0 || (dir_reg ? (c0 > head_reg) : (c0 < head_reg));

    // head movement and wraparound detection against the previous result
    assign diff     = (c0 >= prev_reg) ? c0 - prev_reg : prev_reg - c0;
    assign first    = (emit_reg == '0);
    assign jump_now = !first && (dir_reg ? (c0 > prev_reg) : (c0 < prev_reg));
    assign done_now = (emit_reg == count_reg - CNT_W'(1));
    assign seek_sum = seek_reg + SEEK_W'(diff);

    // ring position of the front cell after a rotation
    assign pos_dn = (pos_reg == POS_W'(DEPTH - 1)) ? '0 : pos_reg + POS_W'(1);
    assign pos_up = (pos_reg == '0) ? POS_W'(DEPTH - 1) : pos_reg - POS_W'(1);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        step_next    = step_reg;
        pos_next     = pos_reg;
        emit_next    = emit_reg;
        dir_next     = dir_reg;
        jump_next    = jump_reg;
        last_next    = last_reg;
        head_next    = head_reg;
        prev_next    = prev_reg;
        seek_next    = seek_reg;
        strobe_next  = 1'b0;
        res_next     = res_reg;

        cmd.op      = OP_HOLD;
        cmd.ins_val = request_track[TRACK_BITS-1:0];
        cmd.count   = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        cmd.op     = OP_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last_request)
                    begin
                        state_next = ST_ADD;
                        step_next  = '0;
                        last_next  = last_m[TRACK_BITS-1:0];
                        head_next  = head_m[TRACK_BITS-1:0];
                        dir_next   = cfg.direction;
                    end
                end
            end
            ST_ADD:
            begin
                // head, track zero and last track join the sorted chain
                cmd.op = OP_INSERT;
                unique case (step_reg)
                    2'd0:    cmd.ins_val = head_reg;
                    2'd1:    cmd.ins_val = '0;
                    default: cmd.ins_val = last_reg;
                endcase
                count_next = count_reg + CNT_W'(1);
                step_next  = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    pos_next   = '0;
                    emit_next  = '0;
                    state_next = dir_reg ? ST_ALIGN : ST_SEEK;
                end
            end
            ST_ALIGN:
            begin
                // downward sweep starts from the top of the chain
                cmd.op     = OP_ROT_UP;
                pos_next   = pos_up;
                state_next = ST_SEEK;
            end
            ST_SEEK:
            begin
                if (skip)
                begin
                    cmd.op   = dir_reg ? OP_ROT_UP : OP_ROT_DN;
                    pos_next = dir_reg ? pos_up : pos_dn;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.op   = dir_reg ? OP_ROT_UP : OP_ROT_DN;
                pos_next = dir_reg ? pos_up : pos_dn;
                if (valid0)
                begin
                    strobe_next         = 1'b1;
                    emit_next           = emit_reg + CNT_W'(1);
                    prev_next           = c0;
                    seek_next           = first ? '0 : seek_sum;
                    jump_next           = first ? 1'b0 : (jump_reg || jump_now);
                    res_next.track      = FIELD_W'(c0);
                    res_next.after_jump = jump_next;
                    res_next.seek       = seek_next;
                    res_next.overflow   = dropped_reg;
                    res_next.end_of_run = done_now;
                    if (done_now)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_next.strobe = strobe_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            step_reg    <= '0;
            pos_reg     <= '0;
            emit_reg    <= '0;
            dir_reg     <= 1'b0;
            jump_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            step_reg    <= step_next;
            pos_reg     <= pos_next;
            emit_reg    <= emit_next;
            dir_reg     <= dir_next;
            jump_reg    <= jump_next;
            strobe_reg  <= strobe_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        head_reg <= head_next;
        prev_reg <= prev_next;
        seek_reg <= seek_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        res        = res_reg;
        res.strobe = strobe_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cscan_disk_scheduler.sv =====
// c-scan disk scheduler top level: configuration registers, cell chain, sequencer
// depends on cscan_pkg, cscan_cell, cscan_ctrl and cscan_disk_scheduler_macros.svh
// loading: one request per cycle, each inserted into the sorted chain as it is accepted
// after the closing request: head, track 0 and last track are inserted, then an alignment
// rotation for downward sweeps, then the ring rotates until the front reaches the head
// results: at most one per cycle from the front cell, n = accepted requests + 3, with gaps while
// empty cells pass the front; busy falls as the final result appears, the receiver
// cannot stall
// reset: asynchronous active low, clears the batch and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "cscan_disk_scheduler_macros.svh"

module cscan_disk_scheduler
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cscan_pkg::FIELD_W-1:0]      request_track,
    input  logic                               last_request,
    input  logic                               cfg_write,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cscan_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                               result_strobe,
    output logic [cscan_pkg::FIELD_W-1:0]      service_track,
    output logic                               after_jump,
    output logic [cscan_pkg::SEEK_W-1:0]       running_seek,
    output logic                               overflow,
    output logic                               end_of_run
);
    import cscan_pkg::*;

    logic [CFG_DATA_W-1:0] track_count_reg, track_count_next;
    logic [CFG_DATA_W-1:0] head_track_reg, head_track_next;
    logic                  direction_reg, direction_next;

    cfg_t       cfg;
    chain_cmd_t cmd;
    result_t    res;
    track_t     cell_val [DEPTH];
    logic       cell_gt  [DEPTH];

    // configuration registers
    always_comb
    begin
        track_count_next = track_count_reg;
        head_track_next  = head_track_reg;
        direction_next   = direction_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRACK_COUNT: track_count_next = cfg_data;
                REG_HEAD_TRACK:  head_track_next  = cfg_data;
                REG_DIRECTION:   direction_next   = cfg_data[0];
                default:         track_count_next = track_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg <= TRACK_COUNT_RST;
            head_track_reg  <= HEAD_TRACK_RST;
            direction_reg   <= 1'b0;
        end
        else
        begin
            track_count_reg <= track_count_next;
            head_track_reg  <= head_track_next;
            direction_reg   <= direction_next;
        end
    end

    assign cfg.track_count = track_count_reg;
    assign cfg.head_track  = head_track_reg;
    assign cfg.direction   = direction_reg;

    // sequencer
    cscan_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .request_track (request_track),
        .last_request  (last_request),
        .cfg           (cfg),
        .cell0         (cell_val[0]),
        .busy          (busy),
        .cmd           (cmd),
        .res           (res)
    );

    // ring of cells; cell 0 is the front, its lower neighbor is the top cell
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam int LO = (g == 0) ? DEPTH - 1 : g - 1;
        localparam int HI = (g == DEPTH - 1) ? 0 : g + 1;
        logic lo_gt;

        if (g == 0)
        begin : g_front
            assign lo_gt = 1'b0;
        end
        else
        begin : g_inner
            assign lo_gt = cell_gt[LO];
        end

        cscan_cell u_cell
        (
            .clk    (clk),
            .cmd    (cmd),
            .idx    (CNT_W'(g)),
            .lo_val (cell_val[LO]),
            .lo_gt  (lo_gt),
            .hi_val (cell_val[HI]),
            .val    (cell_val[g]),
            .gt     (cell_gt[g])
        );
    end

    // result ports
    assign result_strobe = res.strobe;
    assign service_track = res.track;
    assign after_jump    = res.after_jump;
    assign running_seek  = res.seek;
    assign overflow      = res.overflow;
    assign end_of_run    = res.end_of_run;

    // checks
    `CSCAN_ASSERT_NEXT(a_close_busy, start && !busy && last_request, busy, "batch close not busy")
    `CSCAN_ASSERT_NEXT(a_end_quiet, result_strobe && end_of_run, !result_strobe, "item after end of run")
    `CSCAN_ASSERT_SAME(a_idle_at_end, $fell(busy), result_strobe && end_of_run, "busy fell early")
    `CSCAN_ASSERT_NEXT(a_jump_sticky, result_strobe && after_jump, !(result_strobe && !after_jump), "jump flag dropped")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the c-scan disk scheduler: directed batches, then random batches
// under several sender idling phases, checked against an in-bench schedule predictor
// depends on cscan_pkg and the cscan_disk_scheduler rtl
`timescale 1ns / 1ps

module tb_top;

    import cscan_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 80;
    localparam int MAX_GAP       = 40;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int PRINT_LIMIT   = 50;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    typedef struct {
        track_t track;
        logic   after_jump;
        seek_t  seek;
        logic   overflow;
        logic   end_flag;
    } visit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [FIELD_W-1:0]    request_track = '0;
    logic                  last_request = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  result_strobe;
    logic [FIELD_W-1:0]    service_track;
    logic                  after_jump;
    logic [SEEK_W-1:0]     running_seek;
    logic                  overflow;
    logic                  end_of_run;

    // predictor copy of the registers and of the open batch
    logic [CFG_DATA_W-1:0] cfg_track_count = TRACK_COUNT_RST;
    logic [CFG_DATA_W-1:0] cfg_head_track  = HEAD_TRACK_RST;
    logic                  cfg_direction   = 1'b0;
    track_t                batch_tracks[$];
    logic                  batch_dropped = 1'b0;

    visit_t pending_visits[$];
    int     error_count = 0;
    int     sender_idle_pct = 0;

    always #6 clk = ~clk;

    cscan_disk_scheduler dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request_track (request_track),
        .last_request  (last_request),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .service_track (service_track),
        .after_jump    (after_jump),
        .running_seek  (running_seek),
        .overflow      (overflow),
        .end_of_run    (end_of_run)
    );

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
        error_count++;
    endtask

    // ascending insertion, equal values land after existing ones
    function automatic void add_sorted(ref track_t q[$], input track_t v);
        int i;
        i = q.size();
        while (i > 0 && q[i-1] > v)
        begin
            i--;
        end
        q.insert(i, v);
    endfunction

    function automatic void push_visit(input track_t trk, input logic jumped,
                                       input int unsigned seek);
        visit_t v;
        v.track      = trk;
        v.after_jump = jumped;
        v.seek       = seek_t'(seek);
        v.overflow   = batch_dropped;
        v.end_flag   = 1'b0;
        pending_visits.push_back(v);
    endfunction

    // store one request; on the closing one build the c-scan service order
    task automatic predict_service_order(input track_t req, input logic is_last);
        track_t      lst;
        track_t      hd;
        track_t      order[$];
        int unsigned seek;
        int          n;
        int          pos;
        if (batch_tracks.size() < MAX_REQUESTS)
            add_sorted(batch_tracks, req);
        else
            batch_dropped = 1'b1;
        if (!is_last)
            return;

        // clamp with the registers as they stand now
        lst = (cfg_track_count == '0) ? track_t'(0) : track_t'(cfg_track_count - 1'b1);
        if (lst > TRACK_MASK)
            lst = TRACK_MASK;
        hd = (cfg_head_track > lst) ? lst : track_t'(cfg_head_track);
        order = {};
        foreach (batch_tracks[i])
        begin
            order.push_back(batch_tracks[i] > lst ? lst : batch_tracks[i]);
        end
        add_sorted(order, hd);
        add_sorted(order, track_t'(0));
        add_sorted(order, lst);
        n = order.size();
        seek = 0;

        if (cfg_direction == 1'b0)
        begin
            // upward from the first entry equal to the head
            pos = 0;
            while (order[pos] != hd)
                pos++;
            for (int i = pos; i < n; i++)
            begin
                if (i > pos)
                    seek += order[i] - order[i-1];
                push_visit(order[i], 1'b0, seek);
            end
            if (pos > 0)
            begin
                seek += lst;
                for (int i = 0; i < pos; i++)
                begin
                    if (i > 0)
                        seek += order[i] - order[i-1];
                    push_visit(order[i], 1'b1, seek);
                end
            end
        end
        else
        begin
            // downward from the last entry equal to the head
            pos = n - 1;
            while (pos > 0 && order[pos] != hd)
                pos--;
            for (int i = pos; i >= 0; i--)
            begin
                if (i < pos)
                    seek += order[i+1] - order[i];
                push_visit(order[i], 1'b0, seek);
            end
            if (pos < n - 1)
            begin
                seek += lst;
                for (int i = n - 1; i > pos; i--)
                begin
                    if (i < n - 1)
                        seek += order[i+1] - order[i];
                    push_visit(order[i], 1'b1, seek);
                end
            end
        end

        pending_visits[pending_visits.size()-1].end_flag = 1'b1;
        batch_tracks = {};
        batch_dropped = 1'b0;
    endtask

    // compare each result with the oldest expected visit
    always @(posedge clk)
    begin : result_check
        visit_t want;
        if (rst_n && result_strobe === 1'b1)
        begin
            if (pending_visits.size() == 0)
            begin
                report_error($sformatf("unexpected result, track %0d", service_track));
            end
            else
            begin
                want = pending_visits.pop_front();
                if (service_track !== want.track)
                    report_error($sformatf("service_track got %0d expected %0d",
                                           service_track, want.track));
                if (after_jump !== want.after_jump)
                    report_error($sformatf("after_jump got %b expected %b",
                                           after_jump, want.after_jump));
                if (running_seek !== want.seek)
                    report_error($sformatf("running_seek got %0d expected %0d",
                                           running_seek, want.seek));
                if (overflow !== want.overflow)
                    report_error($sformatf("overflow got %b expected %b",
                                           overflow, want.overflow));
                if (end_of_run !== want.end_flag)
                    report_error($sformatf("end_of_run got %b expected %b",
                                           end_of_run, want.end_flag));
            end
        end
    end

    // one item; start stays high on return unless an idle gap was drawn
    task automatic send_request(input track_t trk, input logic is_last);
        int gap;
        start         <= 1'b1;
        request_track <= trk;
        last_request  <= is_last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_service_order(trk, is_last);
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every expected visit has come and the block is quiet
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_visits.size() != 0 || busy !== 1'b0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_TRACK_COUNT: cfg_track_count = val;
            REG_HEAD_TRACK:  cfg_head_track  = val;
            REG_DIRECTION:   cfg_direction   = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_disk(input logic [CFG_DATA_W-1:0] count,
                            input logic [CFG_DATA_W-1:0] head, input logic dir);
        write_reg(REG_TRACK_COUNT, count);
        write_reg(REG_HEAD_TRACK, head);
        write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    endtask

    // reset values, stored tracks on the head, upward with no jump
    task automatic test_default_registers();
        sender_idle_pct = 0;
        send_request(16'd50, 1'b0);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd120, 1'b1);
        wait_idle();
    endtask

    // downward sweep with a request on the head and a wrap to the end
    task automatic test_downward_sweep();
        sender_idle_pct = 13;
        set_disk(16'd200, 16'd100, 1'b1);
        send_request(16'd100, 1'b0);
        send_request(16'd150, 1'b0);
        send_request(16'd20, 1'b0);
        send_request(16'd100, 1'b1);
        wait_idle();
    endtask

    // head above the last track is pulled down to it
    task automatic test_head_clamp();
        sender_idle_pct = 0;
        set_disk(16'd300, 16'd65534, 1'b0);
        send_request(16'd5, 1'b0);
        send_request(16'hFFFF, 1'b1);
        wait_idle();
    endtask

    // track count shrinks while a batch is open: clamping uses the new value
    task automatic test_clamp_at_close();
        sender_idle_pct = 0;
        set_disk(16'hFFFF, 16'd40000, 1'b1);
        send_request(16'd60000, 1'b0);
        send_request(16'd30, 1'b0);
        wait_idle();
        write_reg(REG_TRACK_COUNT, 16'd1000);
        send_request(16'd999, 1'b1);
        wait_idle();
    endtask

    // zero and one track disks, and a two track disk with the head at the end
    task automatic test_tiny_disk();
        sender_idle_pct = 0;
        set_disk(16'd0, 16'd5, 1'b0);
        send_request(16'd7, 1'b1);
        wait_idle();
        set_disk(16'd1, 16'd5, 1'b1);
        send_request(16'hFFFF, 1'b1);
        wait_idle();
        set_disk(16'd2, 16'd1, 1'b1);
        send_request(16'd0, 1'b1);
        wait_idle();
    endtask

    // widest disk, write to the unused index must change nothing
    task automatic test_full_range();
        sender_idle_pct = 0;
        set_disk(16'hFFFF, 16'd65534, 1'b0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_request(16'hFFFF, 1'b0);
        send_request(16'h8000, 1'b0);
        send_request(16'd1, 1'b1);
        wait_idle();
    endtask

    function automatic track_t pick_track();
        case ($urandom_range(6))
            0:       return track_t'(0);
            1:       return track_t'(16'hFFFF);
            2:       return track_t'($urandom_range(0, cfg_track_count));
            3:       return track_t'(cfg_head_track);
            4:       return track_t'(cfg_track_count - 1'b1);
            default: return track_t'($urandom);
        endcase
    endfunction

    task automatic randomize_disk();
        logic [CFG_DATA_W-1:0] count;
        logic [CFG_DATA_W-1:0] head;
        case ($urandom_range(5))
            0:       count = CFG_DATA_W'($urandom_range(0, 3));
            1:       count = 16'hFFFF;
            2, 3:    count = CFG_DATA_W'($urandom_range(2, 400));
            default: count = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       head = '0;
            1:       head = CFG_DATA_W'($urandom_range(0, count));
            2:       head = 16'hFFFF;
            default: head = CFG_DATA_W'($urandom);
        endcase
        set_disk(count, head, 1'($urandom_range(1)));
    endtask

    // random batches, some past capacity, reconfiguring between some of them
    task automatic test_random_batches(input int idle_pct, input int item_goal);
        int sent;
        int batch_len;
        int pick;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < item_goal)
        begin
            pick = $urandom_range(99);
            if (sent == 0 && idle_pct == 0)
                batch_len = MAX_REQUESTS + 2;
            else if (pick < 12)
                batch_len = $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 5);
            else if (pick < 30)
                batch_len = $urandom_range(1, 3);
            else
                batch_len = $urandom_range(4, MAX_REQUESTS);
            for (int j = 0; j < batch_len; j++)
            begin
                send_request(pick_track(), j == batch_len - 1);
            end
            sent += batch_len;
            if ($urandom_range(2) == 0)
            begin
                wait_idle();
                randomize_disk();
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_default_registers();
        test_downward_sweep();
        test_head_clamp();
        test_clamp_at_close();
        test_tiny_disk();
        test_full_range();
        test_random_batches(0, 30);
        test_random_batches(83, 30);
        test_random_batches(13, 30);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_visits.size() != 0)
            report_error($sformatf("%0d expected visits never came", pending_visits.size()));
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== cscan_disk_scheduler.f =====
+incdir+hw/rtl
hw/rtl/cscan_pkg.sv
hw/rtl/cscan_cell.sv
hw/rtl/cscan_ctrl.sv
hw/rtl/cscan_disk_scheduler.sv
test/tb_top.sv
